@@ rtl/coag_pkg.sv @@
`timescale 1ns / 1ps
package coag_pkg;

    localparam int MAX_RADIUS        = 90;
    localparam int ROW_PITCH         = 320;
    localparam int MAX_STEPS         = 64;
    localparam int DEFAULT_ROM_DEPTH = 1024;

    localparam int X_W      = 9;
    localparam int Y_W      = 8;
    localparam int R_W      = 7;
    localparam int COLOR_W  = 8;
    localparam int ADDR_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int INV_W    = FRAC_W + 1;
    localparam int ARC_W    = FRAC_W + 1;
    localparam int N_W      = 22;
    localparam int DIV_STEPS = INV_W;
    localparam int CNT_W    = $clog2(MAX_STEPS);

    localparam logic [INV_W-1:0] ONE_FIXED = INV_W'(32'h10000);

    typedef struct packed {
        logic load;
        logic div_step;
        logic prime;
        logic walk;
        logic emit;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic radius_zero;
        logic dy_valid;
        logic walk_end;
    } t_sts;

    // Largest y with (y * depth)^2 <= (depth^2 - i^2) * 2^32, which is
    // floor(65536 * sqrt(1 - (i / depth)^2)).
    function automatic logic [ARC_W-1:0] arc_entry(input int unsigned i,
                                                   input int unsigned depth);
        logic [63:0]      lim;
        logic [63:0]      t;
        logic [ARC_W-1:0] y;
        logic [ARC_W-1:0] c;
        lim = (64'(depth) * 64'(depth) - 64'(i) * 64'(i)) << 32;
        y   = '0;
        for (int b = ARC_W - 1; b >= 0; b--) begin
            c = y | (ARC_W'(1) << b);
            t = 64'(c) * 64'(depth);
            if (t * t <= lim) begin
                y = c;
            end
        end
        return y;
    endfunction

endpackage

@@ rtl/coag_ctrl.sv @@
`timescale 1ns / 1ps
module coag_ctrl
    import coag_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_PRIME = 4'b0100,
        S_WALK  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    if (!i_sts.radius_zero) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_cnt       = '0;
                n_state     = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.dy_valid) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_sts.walk_end || (r_cnt == CNT_W'(MAX_STEPS - 1));
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_sts.radius_zero) |=> (r_state == S_DIV))
        else $error("accepted item with nonzero radius did not start the divider");

    a_zero_radius_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_sts.radius_zero) |=> !o_busy)
        else $error("zero radius item left the block busy");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> !o_busy)
        else $error("block still busy after the final step");

    a_prime_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRIME) |=> ((r_state == S_WALK) && (r_cnt == '0)))
        else $error("walk did not begin with a cleared step count");

endmodule

@@ rtl/coag_datapath.sv @@
`timescale 1ns / 1ps
module coag_datapath
    import coag_pkg::*;
#(
    parameter int ROM_DEPTH = DEFAULT_ROM_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [X_W-1:0]     i_center_x,
    input  logic [Y_W-1:0]     i_center_y,
    input  logic [R_W-1:0]     i_radius,
    input  logic [COLOR_W-1:0] i_pen_color,
    output logic               o_valid,
    output logic [ADDR_W-1:0]  o_addr_oct0,
    output logic [ADDR_W-1:0]  o_addr_oct1,
    output logic [ADDR_W-1:0]  o_addr_oct2,
    output logic [ADDR_W-1:0]  o_addr_oct3,
    output logic [ADDR_W-1:0]  o_addr_oct4,
    output logic [ADDR_W-1:0]  o_addr_oct5,
    output logic [ADDR_W-1:0]  o_addr_oct6,
    output logic [ADDR_W-1:0]  o_addr_oct7,
    output logic [COLOR_W-1:0] o_out_color,
    output logic               o_last_step
);

    localparam int IDX_W  = $clog2(ROM_DEPTH);
    localparam int DEP_W  = $clog2(ROM_DEPTH + 1);
    localparam int PROD_W = N_W + DEP_W;
    localparam int IDXF_W = PROD_W - FRAC_W;
    localparam int DYP_W  = R_W + ARC_W;

    logic [ARC_W-1:0] w_arc [ROM_DEPTH];

    for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_arc
        assign w_arc[gi] = arc_entry(gi, ROM_DEPTH);
    end

    logic [R_W-1:0]     r_r;
    logic [COLOR_W-1:0] r_color;
    logic [ADDR_W-1:0]  r_off;
    logic [R_W-1:0]     r_rem;
    logic [INV_W-1:0]   r_q;
    logic [N_W-1:0]     r_n;
    logic [PROD_W-1:0]  r_prod;
    logic [ARC_W-1:0]   r_rom;
    logic [R_W-1:0]     r_dyn;
    logic [3:0]         r_v;
    logic [R_W-1:0]     r_dx;
    logic [R_W-1:0]     r_dy;

    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_a0, r_a1, r_a2, r_a3, r_a4, r_a5, r_a6, r_a7;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_last;

    logic [R_W-1:0]     w_r_sat;
    logic [ADDR_W-1:0]  w_off;
    logic [R_W:0]       w_rem_sh;
    logic               w_ge;
    logic [IDXF_W-1:0]  w_idx_full;
    logic               w_oob;
    logic [DYP_W-1:0]   w_dy_prod;
    logic [ADDR_W-1:0]  w_dx, w_dy, w_xo, w_yo;

    assign w_r_sat  = (i_radius > R_W'(MAX_RADIUS)) ? R_W'(MAX_RADIUS) : i_radius;
    assign w_off    = ADDR_W'(32'(i_center_y) * 32'(ROW_PITCH) + 32'(i_center_x));
    assign w_rem_sh = {r_rem, r_q[INV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_r});

    assign w_idx_full = r_prod[PROD_W-1:FRAC_W];
    assign w_oob      = (w_idx_full >= IDXF_W'(ROM_DEPTH));
    assign w_dy_prod  = DYP_W'(r_r) * DYP_W'(r_rom);

    assign w_dx = ADDR_W'(r_dx);
    assign w_dy = ADDR_W'(r_dy);
    assign w_xo = ADDR_W'(32'(r_dx) * 32'(ROW_PITCH));
    assign w_yo = ADDR_W'(32'(r_dy) * 32'(ROW_PITCH));

    assign o_sts.radius_zero = (i_radius == '0);
    assign o_sts.dy_valid    = r_v[3];
    assign o_sts.walk_end    = (({1'b0, r_dx} + (R_W + 1)'(1)) > {1'b0, r_dyn});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r     <= w_r_sat;
            r_color <= i_pen_color;
            r_off   <= w_off;
            r_rem   <= '0;
            r_q     <= ONE_FIXED;
            r_dx    <= '0;
            r_dy    <= w_r_sat - R_W'(1);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? R_W'(w_rem_sh - {1'b0, r_r}) : w_rem_sh[R_W-1:0];
            r_q   <= {r_q[INV_W-2:0], w_ge};
        end
        if (i_cmd.prime) begin
            r_n <= N_W'(r_q);
        end else if (i_cmd.walk) begin
            r_n <= r_n + N_W'(r_q);
        end
        r_prod <= PROD_W'(r_n) * PROD_W'(ROM_DEPTH);
        r_rom  <= w_oob ? '0 : w_arc[w_idx_full[IDX_W-1:0]];
        r_dyn  <= w_dy_prod[FRAC_W +: R_W];
        if (i_cmd.emit) begin
            r_dx        <= r_dx + R_W'(1);
            r_dy        <= r_dyn;
            r_a0        <= r_off + w_dy - w_xo;
            r_a1        <= r_off + w_dx - w_yo;
            r_a2        <= r_off - w_dx - w_yo;
            r_a3        <= r_off - w_dy - w_xo;
            r_a4        <= r_off - w_dy + w_xo;
            r_a5        <= r_off - w_dx + w_yo;
            r_a6        <= r_off + w_dx + w_yo;
            r_a7        <= r_off + w_dy + w_xo;
            r_out_color <= r_color;
            r_last      <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
            if (i_cmd.prime) begin
                r_v <= 4'b0001;
            end else if (i_cmd.walk) begin
                r_v <= {r_v[2:0], 1'b1};
            end else begin
                r_v <= '0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_addr_oct0 = r_a0;
    assign o_addr_oct1 = r_a1;
    assign o_addr_oct2 = r_a2;
    assign o_addr_oct3 = r_a3;
    assign o_addr_oct4 = r_a4;
    assign o_addr_oct5 = r_a5;
    assign o_addr_oct6 = r_a6;
    assign o_addr_oct7 = r_a7;
    assign o_out_color = r_out_color;
    assign o_last_step = r_last;

endmodule

@@ rtl/circle_outline_address_generator_core.sv @@
`timescale 1ns / 1ps
// The first result of a circle follows its item through the radial reciprocal
// divider, the prime step and the 4-stage arc pipeline (r_n, r_prod, r_rom, r_dyn).
// After that, one result per cycle until the last; a new item is taken only
// while busy is low, and a zero radius item never raises busy.
// Results cannot be stalled: each one is valid for exactly one cycle.
// Reset is synchronous and active low; it idles the controller and the strobe.
module circle_outline_address_generator_core
    import coag_pkg::*;
#(
    parameter int ROM_DEPTH = DEFAULT_ROM_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [X_W-1:0]     i_center_x,
    input  logic [Y_W-1:0]     i_center_y,
    input  logic [R_W-1:0]     i_radius,
    input  logic [COLOR_W-1:0] i_pen_color,
    output logic               o_valid,
    output logic [ADDR_W-1:0]  o_addr_oct0,
    output logic [ADDR_W-1:0]  o_addr_oct1,
    output logic [ADDR_W-1:0]  o_addr_oct2,
    output logic [ADDR_W-1:0]  o_addr_oct3,
    output logic [ADDR_W-1:0]  o_addr_oct4,
    output logic [ADDR_W-1:0]  o_addr_oct5,
    output logic [ADDR_W-1:0]  o_addr_oct6,
    output logic [ADDR_W-1:0]  o_addr_oct7,
    output logic [COLOR_W-1:0] o_out_color,
    output logic               o_last_step
);

    t_cmd w_cmd;
    t_sts w_sts;

    coag_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    coag_datapath #(
        .ROM_DEPTH (ROM_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .i_pen_color (i_pen_color),
        .o_valid     (o_valid),
        .o_addr_oct0 (o_addr_oct0),
        .o_addr_oct1 (o_addr_oct1),
        .o_addr_oct2 (o_addr_oct2),
        .o_addr_oct3 (o_addr_oct3),
        .o_addr_oct4 (o_addr_oct4),
        .o_addr_oct5 (o_addr_oct5),
        .o_addr_oct6 (o_addr_oct6),
        .o_addr_oct7 (o_addr_oct7),
        .o_out_color (o_out_color),
        .o_last_step (o_last_step)
    );

endmodule

@@ tb/circle_step_checker.sv @@
`timescale 1ns / 1ps
module circle_step_checker
    import coag_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [X_W-1:0]     i_center_x,
    input  logic [Y_W-1:0]     i_center_y,
    input  logic [R_W-1:0]     i_radius,
    input  logic [COLOR_W-1:0] i_pen_color,
    input  logic               i_valid,
    input  logic [ADDR_W-1:0]  i_addr_oct0,
    input  logic [ADDR_W-1:0]  i_addr_oct1,
    input  logic [ADDR_W-1:0]  i_addr_oct2,
    input  logic [ADDR_W-1:0]  i_addr_oct3,
    input  logic [ADDR_W-1:0]  i_addr_oct4,
    input  logic [ADDR_W-1:0]  i_addr_oct5,
    input  logic [ADDR_W-1:0]  i_addr_oct6,
    input  logic [ADDR_W-1:0]  i_addr_oct7,
    input  logic [COLOR_W-1:0] i_out_color,
    input  logic               i_last_step,
    output int                 o_mismatch_count,
    output int                 o_steps_outstanding
);

    localparam longint unsigned ARC_DEPTH = DEFAULT_ROM_DEPTH;

    typedef struct packed {
        logic [7:0][ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]     color;
        logic                   last;
    } t_outline_step;

    logic [ARC_W-1:0] arc_height [ARC_DEPTH];
    t_outline_step    pending_steps [$];

    function automatic logic [ARC_W-1:0] arc_height_of(input longint unsigned i);
        longint unsigned d2;
        longint unsigned q;
        longint unsigned y;
        longint unsigned c;
        d2 = ARC_DEPTH * ARC_DEPTH;
        q  = ((d2 - i * i) << 32) / d2;
        y  = 0;
        for (int b = ARC_W - 1; b >= 0; b--) begin
            c = y | (64'd1 << b);
            if (c * c <= q) begin
                y = c;
            end
        end
        return ARC_W'(y);
    endfunction

    initial begin
        o_mismatch_count    = 0;
        o_steps_outstanding = 0;
        for (int i = 0; i < int'(ARC_DEPTH); i++) begin
            arc_height[i] = arc_height_of(i);
        end
    end

    function automatic void trace_outline(input int cx, input int cy, input int radius,
                                          input logic [COLOR_W-1:0] color);
        t_outline_step   s;
        int              rr;
        int              off;
        int              dx;
        int              dy;
        int              count;
        int              xo;
        int              yo;
        longint unsigned acc;
        longint unsigned step;
        longint unsigned idx;
        longint unsigned h;
        rr = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
        if (rr == 0) begin
            return;
        end
        off   = cy * ROW_PITCH + cx;
        step  = 64'h10000 / rr;
        acc   = 0;
        dx    = 0;
        dy    = rr - 1;
        count = 0;
        while (dx <= dy && count < MAX_STEPS) begin
            xo = dx * ROW_PITCH;
            yo = dy * ROW_PITCH;
            s.addr[0] = ADDR_W'(off + dy - xo);
            s.addr[1] = ADDR_W'(off + dx - yo);
            s.addr[2] = ADDR_W'(off - dx - yo);
            s.addr[3] = ADDR_W'(off - dy - xo);
            s.addr[4] = ADDR_W'(off - dy + xo);
            s.addr[5] = ADDR_W'(off - dx + yo);
            s.addr[6] = ADDR_W'(off + dx + yo);
            s.addr[7] = ADDR_W'(off + dy + xo);
            s.color   = color;
            s.last    = 1'b0;
            pending_steps.push_back(s);
            count++;
            dx++;
            acc = acc + step;
            idx = (acc * ARC_DEPTH) >> 16;
            h   = (idx >= ARC_DEPTH) ? 0 : arc_height[idx];
            dy  = int'((longint'(rr) * h) >> 16);
        end
        pending_steps[$].last = 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        o_mismatch_count++;
        $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_step();
        logic [7:0][ADDR_W-1:0] got;
        t_outline_step          want;
        got = {i_addr_oct7, i_addr_oct6, i_addr_oct5, i_addr_oct4,
               i_addr_oct3, i_addr_oct2, i_addr_oct1, i_addr_oct0};
        if (pending_steps.size() == 0) begin
            flag_mismatch("unexpected result", 32'(got[0]), 32'h0);
            return;
        end
        want = pending_steps.pop_front();
        for (int k = 0; k < 8; k++) begin
            if (got[k] !== want.addr[k]) begin
                flag_mismatch($sformatf("addr_oct%0d", k), 32'(got[k]), 32'(want.addr[k]));
            end
        end
        if (i_out_color !== want.color) begin
            flag_mismatch("out_color", 32'(i_out_color), 32'(want.color));
        end
        if (i_last_step !== want.last) begin
            flag_mismatch("last_step", 32'(i_last_step), 32'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                trace_outline(int'(i_center_x), int'(i_center_y), int'(i_radius),
                              i_pen_color);
            end
            if (i_valid !== 1'b0) begin
                check_step();
            end
        end
        o_steps_outstanding = pending_steps.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb
    import coag_pkg::*;
;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic [X_W-1:0]     i_center_x  = '0;
    logic [Y_W-1:0]     i_center_y  = '0;
    logic [R_W-1:0]     i_radius    = '0;
    logic [COLOR_W-1:0] i_pen_color = '0;
    logic               o_valid;
    logic [ADDR_W-1:0]  o_addr_oct0;
    logic [ADDR_W-1:0]  o_addr_oct1;
    logic [ADDR_W-1:0]  o_addr_oct2;
    logic [ADDR_W-1:0]  o_addr_oct3;
    logic [ADDR_W-1:0]  o_addr_oct4;
    logic [ADDR_W-1:0]  o_addr_oct5;
    logic [ADDR_W-1:0]  o_addr_oct6;
    logic [ADDR_W-1:0]  o_addr_oct7;
    logic [COLOR_W-1:0] o_out_color;
    logic               o_last_step;
    int                 mismatch_count;
    int                 steps_outstanding;
    bit                 quiet = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    circle_outline_address_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .i_pen_color (i_pen_color),
        .o_valid     (o_valid),
        .o_addr_oct0 (o_addr_oct0),
        .o_addr_oct1 (o_addr_oct1),
        .o_addr_oct2 (o_addr_oct2),
        .o_addr_oct3 (o_addr_oct3),
        .o_addr_oct4 (o_addr_oct4),
        .o_addr_oct5 (o_addr_oct5),
        .o_addr_oct6 (o_addr_oct6),
        .o_addr_oct7 (o_addr_oct7),
        .o_out_color (o_out_color),
        .o_last_step (o_last_step)
    );

    circle_step_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_center_x          (i_center_x),
        .i_center_y          (i_center_y),
        .i_radius            (i_radius),
        .i_pen_color         (i_pen_color),
        .i_valid             (o_valid),
        .i_addr_oct0         (o_addr_oct0),
        .i_addr_oct1         (o_addr_oct1),
        .i_addr_oct2         (o_addr_oct2),
        .i_addr_oct3         (o_addr_oct3),
        .i_addr_oct4         (o_addr_oct4),
        .i_addr_oct5         (o_addr_oct5),
        .i_addr_oct6         (o_addr_oct6),
        .i_addr_oct7         (o_addr_oct7),
        .i_out_color         (o_out_color),
        .i_last_step         (o_last_step),
        .o_mismatch_count    (mismatch_count),
        .o_steps_outstanding (steps_outstanding)
    );

    // An occasional gap of random length (none while quiet) lowers start before
    // the next item; each item is held until busy is low again.
    task automatic send_circle(input int x, input int y, input int r, input int c);
        if (!quiet && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_center_x  <= X_W'(x);
        i_center_y  <= Y_W'(y);
        i_radius    <= R_W'(r);
        i_pen_color <= COLOR_W'(c);
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (steps_outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int sel;
        int r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_circle(160, 100, 1, 8'h00);
        send_circle(160, 100, 2, 8'hff);
        send_circle(160, 100, 0, 8'h5a);
        send_circle(0, 0, 90, 8'ha5);
        send_circle(511, 255, 90, 8'h01);
        send_circle(319, 199, 91, 8'h80);
        send_circle(0, 255, 127, 8'h7f);
        send_circle(511, 0, 3, 8'h33);
        send_circle(100, 50, 89, 8'hcc);
        send_circle(200, 150, 45, 8'h0f);
        send_circle(5, 5, 10, 8'hf0);
        send_circle(256, 128, 64, 8'haa);
        send_circle(319, 0, 0, 8'h55);
        send_circle(0, 199, 1, 8'hfe);
        send_circle(160, 100, 127, 8'h00);
        wait_drained();

        for (int k = 0; k < 430; k++) begin
            quiet = (k >= 150 && k < 230);
            if (k == 100 || k == 300) begin
                wait_drained();
            end
            sel = $urandom_range(99);
            if (sel < 6) begin
                r = 0;
            end else if (sel < 14) begin
                r = $urandom_range(91, 127);
            end else if (sel < 26) begin
                r = $urandom_range(1, 4);
            end else begin
                r = $urandom_range(1, 90);
            end
            send_circle(($urandom_range(3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 319),
                        ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 199),
                        r, $urandom_range(0, 255));
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
